/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl files
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* hw/rtl/rsp_pkg.sv */
// shared constants, op codes and the xorshift128 step for the permuter
// no dependencies
package rsp_pkg;

  localparam int MAX_LEN = 64;
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int COUNT_W = 7;
  localparam int WORD_W  = 32;

  localparam int SHIFT_A = 11;
  localparam int SHIFT_B = 19;
  localparam int SHIFT_C = 8;

  localparam logic [WORD_W-1:0] RESET_X = 32'd123456789;
  localparam logic [WORD_W-1:0] RESET_Y = 32'd362436069;
  localparam logic [WORD_W-1:0] RESET_Z = 32'd521288629;
  localparam logic [WORD_W-1:0] RESET_W = 32'd88675123;

  typedef enum logic [2:0] {
    OP_DRAW    = 3'd0,
    OP_SEED    = 3'd1,
    OP_SAVE    = 3'd2,
    OP_RESTORE = 3'd3,
    OP_PERMUTE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    CFG_SEED_X = 2'd0,
    CFG_SEED_Y = 2'd1,
    CFG_SEED_Z = 2'd2,
    CFG_SEED_W = 2'd3
  } cfg_idx_t;

  function automatic logic [WORD_W-1:0] xorshift_next(input logic [WORD_W-1:0] x,
                                                      input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] t;
    t = x ^ (x << SHIFT_A);
    return (w ^ (w >> SHIFT_B)) ^ (t ^ (t >> SHIFT_C));
  endfunction

endpackage

/* hw/rtl/rsp_modulo.sv */
// bit-serial restoring modulo: 32-bit word mod a small count, one bit per cycle
// depends on rsp_pkg
module rsp_modulo import rsp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [LEN_W-1:0]  divisor,
  output logic              done,
  output logic [IDX_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(WORD_W);

  logic [WORD_W-1:0] quo;
  logic [LEN_W-1:0]  part;
  logic [CNT_W-1:0]  bit_cnt;
  logic              busy;
  logic [LEN_W:0]    trial;

  assign trial     = {part, quo[WORD_W-1]};
  assign remainder = part[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        bit_cnt <= '0;
        quo     <= dividend;
        part    <= '0;
      end else if (busy) begin
        quo <= quo << 1;
        if (trial >= {1'b0, divisor}) begin
          part <= LEN_W'(trial - {1'b0, divisor});
        end else begin
          part <= LEN_W'(trial);
        end
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_cnt == CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/random_sequence_permuter.sv */
// random_sequence_permuter: xorshift128 draw, seed, save, restore and permute
// depends on rsp_pkg, rsp_modulo, assert_macros.svh
// steps: seed, save, restore act in idle; draw waits in ST_DRAW for a free output;
//   permute of n values fills n entries, then per result a generator step, the modulo, a
//   list read and a shift of later entries (none for the last entry); one item at a time
// rst is synchronous: generator = seed resets, backup = 0; the list memory is not cleared
`include "assert_macros.svh"
module random_sequence_permuter import rsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // count[6:0], start_req[38:7], zero pad
  input  logic [2:0]  s_tuser,   // op[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // value[31:0]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DRAW, ST_FILL, ST_GEN, ST_DIV, ST_READ, ST_DATA, ST_SHIFT
  } state_t;

  state_t            state;
  logic [WORD_W-1:0] seed [4];
  logic [WORD_W-1:0] gen  [4];
  logic [WORD_W-1:0] bak  [4];
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] start_val;
  logic [LEN_W-1:0]  rem_cnt;
  logic [IDX_W-1:0]  fill_idx;
  logic [IDX_W-1:0]  c_idx;
  logic [LEN_W-1:0]  k;
  logic              wr_pend;
  logic [IDX_W-1:0]  wr_addr;
  logic              out_valid;
  logic [WORD_W-1:0] out_data;
  logic              out_last;

  logic [IDX_W-1:0]  list_mem [MAX_LEN];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [IDX_W-1:0]  mem_wdata;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  rd_data;

  logic [WORD_W-1:0] new_w;
  logic              div_start;
  logic              div_done;
  logic [IDX_W-1:0]  div_rem;
  logic              out_free;
  logic              out_load;
  logic [2:0]        in_op;
  logic [COUNT_W-1:0] in_count;
  logic [WORD_W-1:0] in_start;
  logic [LEN_W-1:0]  cnt_sat;
  logic [LEN_W-1:0]  k_inc;

  assign in_op    = s_tuser;
  assign in_count = s_tdata[COUNT_W-1:0];
  assign in_start = s_tdata[COUNT_W+WORD_W-1:COUNT_W];
  assign cnt_sat  = (in_count > COUNT_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : LEN_W'(in_count);
  assign new_w    = xorshift_next(gen[0], gen[3]);
  assign out_free = !out_valid || m_tready;
  assign out_load = out_free && (state == ST_DRAW || state == ST_DATA);
  assign k_inc    = k + 1'b1;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;
  assign div_start = (state == ST_GEN);

  rsp_modulo u_modulo (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (new_w),
    .divisor   (rem_cnt),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = rd_data;
    rd_addr   = c_idx;
    unique case (state)
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_idx;
        mem_wdata = fill_idx;
      end
      ST_SHIFT: begin
        mem_we  = wr_pend;
        rd_addr = k_inc[IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      list_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= list_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed[0] <= RESET_X;
      seed[1] <= RESET_Y;
      seed[2] <= RESET_Z;
      seed[3] <= RESET_W;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SEED_X: seed[0] <= cfg_data;
        CFG_SEED_Y: seed[1] <= cfg_data;
        CFG_SEED_Z: seed[2] <= cfg_data;
        CFG_SEED_W: seed[3] <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      gen[0]    <= RESET_X;
      gen[1]    <= RESET_Y;
      gen[2]    <= RESET_Z;
      gen[3]    <= RESET_W;
      bak[0]    <= '0;
      bak[1]    <= '0;
      bak[2]    <= '0;
      bak[3]    <= '0;
      rem_cnt   <= '0;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            unique case (in_op)
              OP_DRAW: begin
                gen[0] <= gen[1];
                gen[1] <= gen[2];
                gen[2] <= gen[3];
                gen[3] <= new_w;
                word   <= new_w;
                state  <= ST_DRAW;
              end
              OP_SEED: begin
                gen <= seed;
              end
              OP_SAVE: begin
                bak <= gen;
              end
              OP_RESTORE: begin
                gen <= bak;
              end
              OP_PERMUTE: begin
                if (cnt_sat != '0) begin
                  rem_cnt   <= cnt_sat;
                  fill_idx  <= '0;
                  start_val <= in_start;
                  state     <= ST_FILL;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_DRAW: begin
          if (out_free) begin
            out_data  <= word;
            out_last  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        ST_FILL: begin
          fill_idx <= fill_idx + 1'b1;
          if (LEN_W'(fill_idx) == rem_cnt - 1'b1) begin
            state <= ST_GEN;
          end
        end
        ST_GEN: begin
          gen[0] <= gen[1];
          gen[1] <= gen[2];
          gen[2] <= gen[3];
          gen[3] <= new_w;
          state  <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            c_idx <= div_rem;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_DATA;
        end
        ST_DATA: begin
          if (out_free) begin
            out_data  <= start_val + WORD_W'(rd_data);
            out_last  <= (rem_cnt == LEN_W'(1));
            k         <= LEN_W'(c_idx);
            wr_pend   <= 1'b0;
            state     <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (k_inc < rem_cnt) begin
            wr_pend <= 1'b1;
            wr_addr <= k[IDX_W-1:0];
            k       <= k_inc;
          end else begin
            wr_pend <= 1'b0;
            if (!wr_pend) begin
              rem_cnt <= rem_cnt - 1'b1;
              state   <= (rem_cnt == LEN_W'(1)) ? ST_IDLE : ST_GEN;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_rem_in_range, clk, rst, rem_cnt <= LEN_W'(MAX_LEN), "remaining count too large")
  `ASSERT_IMPL(a_done_in_div, clk, rst, div_done, state == ST_DIV, "modulo done outside divide")
  `ASSERT_IMPL(a_shift_write_in_list, clk, rst, state == ST_SHIFT && wr_pend, LEN_W'(wr_addr) < rem_cnt, "shift write beyond list")

endmodule

/* dv/random_sequence_permuter_tb.sv */
// testbench for random_sequence_permuter: xorshift128 draw, seed, save, restore, permute
// scoreboard with its own generator model, random stalls on both stream sides
// depends on rsp_pkg and the random_sequence_permuter rtl
`timescale 1ns / 100ps
module random_sequence_permuter_tb;
  import rsp_pkg::*;

  localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;
  localparam int CYCLE_LIMIT  = 10_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_ERR_LINES = 30;

  typedef struct {
    logic [2:0]  op;
    logic [6:0]  count;
    logic [31:0] first;
  } perm_item_t;

  typedef struct {
    logic [31:0] value;
    logic        last;
  } perm_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;    // count[6:0], start_req[38:7], zero pad
  logic [2:0]  s_tuser = '0;    // op[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // value[31:0]
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  random_sequence_permuter u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // generator model state
  logic [31:0] seed_regs [4] = '{RESET_X, RESET_Y, RESET_Z, RESET_W};
  logic [31:0] gen_state [4] = '{RESET_X, RESET_Y, RESET_Z, RESET_W};
  logic [31:0] backup_state [4] = '{32'd0, 32'd0, 32'd0, 32'd0};

  perm_item_t   pending_items [$];
  perm_result_t expected_results [$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  logic in_taken = 1'b0;
  int  error_count = 0;
  int  items_taken = 0;
  int  permutes_taken = 0;
  int  results_checked = 0;
  int  cfg_writes = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] gen_advance();
    logic [31:0] t;
    logic [31:0] w;
    t = gen_state[0] ^ (gen_state[0] << SHIFT_A);
    w = gen_state[3];
    gen_state[0] = gen_state[1];
    gen_state[1] = gen_state[2];
    gen_state[2] = w;
    w = (w ^ (w >> SHIFT_B)) ^ (t ^ (t >> SHIFT_C));
    gen_state[3] = w;
    return w;
  endfunction

  task automatic predict_item(input logic [2:0] op, input logic [6:0] count,
                              input logic [31:0] first);
    logic [31:0] pool [MAX_LEN];
    logic [31:0] word;
    int remaining;
    int pick;
    case (op)
      OP_DRAW: begin
        expected_results.push_back('{gen_advance(), 1'b1});
      end
      OP_SEED:    gen_state = seed_regs;
      OP_SAVE:    backup_state = gen_state;
      OP_RESTORE: gen_state = backup_state;
      OP_PERMUTE: begin
        permutes_taken++;
        remaining = (count > MAX_LEN) ? MAX_LEN : int'(count);
        for (int i = 0; i < remaining; i++) pool[i] = first + 32'(i);
        while (remaining > 0) begin
          word = gen_advance();
          pick = int'(word % 32'(remaining));
          expected_results.push_back('{pool[pick], remaining == 1});
          for (int k = pick; k < remaining - 1; k++) pool[k] = pool[k + 1];
          remaining--;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_ERR_LINES)
      $display("ERROR %0t: %s got 0x%08h expected 0x%08h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic check_result(input logic [31:0] value, input logic last);
    perm_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result transfer", value, 32'd0);
    end else begin
      want = expected_results.pop_front();
      results_checked++;
      if (value !== want.value) report_mismatch("value", value, want.value);
      if (last !== want.last) report_mismatch("last", 32'(last), 32'(want.last));
    end
  endtask

  // acceptance and result monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_item(s_tuser, s_tdata[6:0], s_tdata[38:7]);
        items_taken++;
      end
      if (m_tvalid && m_tready) check_result(m_tdata, m_tlast);
    end
    in_taken <= !rst && s_tvalid && s_tready;
  end

  // stream driver
  always @(negedge clk) begin
    perm_item_t itm;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || in_taken) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          itm = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= itm.op;
          s_tdata  <= {1'b0, itm.first, itm.count};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_item(input logic [2:0] op, input logic [6:0] count,
                          input logic [31:0] first);
    pending_items.push_back('{op, count, first});
  endtask

  task automatic write_seed_reg(input cfg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    seed_regs[idx] = val;
    cfg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_seed_all(input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] z, input logic [31:0] w);
    write_seed_reg(CFG_SEED_X, x);
    write_seed_reg(CFG_SEED_Y, y);
    write_seed_reg(CFG_SEED_Z, z);
    write_seed_reg(CFG_SEED_W, w);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_random_items(input int n);
    int made;
    int r;
    logic [6:0]  cnt;
    logic [31:0] first;
    made = 0;
    while (made < n) begin
      r = $urandom_range(99);
      cnt = 7'($urandom);
      first = $urandom;
      if (r < 35) begin
        add_item(OP_DRAW, cnt, first);
      end else if (r < 65) begin
        r = $urandom_range(99);
        if (r < 80) cnt = 7'($urandom_range(8));
        else if (r < 95) cnt = 7'($urandom_range(40, 9));
        else cnt = 7'($urandom_range(127, 41));
        r = $urandom_range(99);
        if (r < 25) first = 32'hFFFF_FFFF - 32'($urandom_range(20));
        else if (r < 35) first = 32'h7FFF_FFFF - 32'($urandom_range(20));
        add_item(OP_PERMUTE, cnt, first);
      end else if (r < 75) begin
        add_item(OP_SEED, cnt, first);
      end else if (r < 85) begin
        add_item(OP_SAVE, cnt, first);
      end else if (r < 95) begin
        add_item(OP_RESTORE, cnt, first);
      end else begin
        // reserved op codes are ignored by the block and not counted
        add_item(3'($urandom_range(OP_RESERVED_LAST, OP_RESERVED_FIRST)), cnt, first);
        made--;
      end
      made++;
    end
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("random_sequence_permuter test failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset state, save and restore, permute corner cases
    send_idle_pct = 26;
    recv_idle_pct = 56;
    add_item(OP_DRAW, 7'd0, 32'd0);
    add_item(OP_DRAW, 7'h7F, 32'hFFFF_FFFF);
    add_item(OP_SEED, 7'd0, 32'd0);
    add_item(OP_DRAW, 7'd0, 32'd0);
    add_item(OP_SAVE, 7'd0, 32'd0);
    add_item(OP_DRAW, 7'd0, 32'd0);
    add_item(OP_DRAW, 7'd0, 32'd0);
    add_item(OP_RESTORE, 7'd0, 32'd0);
    add_item(OP_DRAW, 7'd0, 32'd0);
    add_item(OP_PERMUTE, 7'd0, 32'd5);
    add_item(OP_PERMUTE, 7'd1, 32'h7FFF_FFFF);
    add_item(OP_PERMUTE, 7'd5, 32'hFFFF_FFFE);
    add_item(OP_PERMUTE, 7'd64, 32'h8000_0000);
    add_item(OP_PERMUTE, 7'd127, $urandom);
    add_item(OP_PERMUTE, 7'd65, 32'h7FFF_FFF0);
    for (int op = OP_RESERVED_FIRST; op <= OP_RESERVED_LAST; op++)
      add_item(3'(op), 7'($urandom), $urandom);
    add_item(OP_DRAW, 7'd0, 32'd0);
    wait_drained();

    // all-zero generator: every draw is zero, permute keeps input order
    write_seed_all(32'd0, 32'd0, 32'd0, 32'd0);
    add_item(OP_SEED, 7'd0, 32'd0);
    add_item(OP_DRAW, 7'd0, 32'd0);
    add_item(OP_PERMUTE, 7'd3, 32'd100);
    wait_drained();

    write_seed_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(OP_SEED, 7'd0, 32'd0);
    add_item(OP_DRAW, 7'd0, 32'd0);
    add_item(OP_PERMUTE, 7'd4, 32'hFFFF_FFFF);
    add_item(OP_DRAW, 7'd0, 32'd0);
    wait_drained();

    // random part, sender stalls less than receiver
    write_seed_all($urandom, $urandom, $urandom, $urandom);
    add_item(OP_SEED, 7'd0, 32'd0);
    add_random_items(85);
    wait_drained();

    // receiver stalls less than sender
    send_idle_pct = 56;
    recv_idle_pct = 26;
    write_seed_all($urandom, $urandom, $urandom, $urandom);
    add_item(OP_SEED, 7'd0, 32'd0);
    add_random_items(85);
    wait_drained();

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_seed_all(32'd0, 32'hFFFF_FFFF, $urandom, 32'd1);
    add_item(OP_SEED, 7'd0, 32'd0);
    add_random_items(85);
    wait_drained();

    $display("ran %0d items with %0d permutes and %0d seed register writes",
             items_taken, permutes_taken, cfg_writes);
    $display("checked %0d results, %0d mismatches", results_checked, error_count);
    if (error_count == 0) begin
      $display("random_sequence_permuter test passed");
    end else begin
      $display("random_sequence_permuter test failed");
    end
    $finish;
  end

endmodule
